FILE: rtl/chauvenet_outlier_mean_core_defines.svh
// Assertion macros for the outlier-rejected mean core.
// Included by the top level; relies on signals named clk and rst_n in scope.
`ifndef CHAUVENET_OUTLIER_MEAN_CORE_DEFINES_SVH
`define CHAUVENET_OUTLIER_MEAN_CORE_DEFINES_SVH
`ifndef ASSERT_OFF
`define COM_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("core assertion failed");
`define COM_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("core implication failed");
`else
`define COM_ASSERT(label, prop)
`define COM_ASSERT_IMPL(label, ante, cons)
`endif
`endif

FILE: rtl/com_pkg.sv
// Shared widths and defaults for the outlier-rejected mean core.
// Used by every module of the block; depends on nothing.
package com_pkg;
    localparam int SAMPLE_W        = 24;
    localparam int FRAC_W          = 8;
    localparam int VAL_W           = 32;
    localparam int FACTOR_W        = 12;
    localparam int COUNT_OUT_W     = 9;
    localparam int SQ_W            = 64;
    localparam int MAX_SAMPLES_DEF = 256;
    localparam logic [FACTOR_W-1:0] FACTOR_RESET = 12'd394;
endpackage

FILE: rtl/com_div.sv
// Restoring divider producing one quotient bit per cycle.
// Depends on com_pkg only through the import convention of the project.
module com_div #(
    parameter int NW = 73,
    parameter int DW = 9
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [NW-1:0] dividend,
    input  logic [DW-1:0] divisor,
    output logic          done,
    output logic [NW-1:0] quotient
);
    import com_pkg::*;

    localparam int CNTW = $clog2(NW + 1);

    logic            busy_reg, busy_next;
    logic            done_reg, done_next;
    logic [CNTW-1:0] cnt_reg, cnt_next;
    logic [NW-1:0]   quo_reg, quo_next;
    logic [DW-1:0]   rem_reg, rem_next;
    logic [DW-1:0]   dvs_reg, dvs_next;
    logic [DW:0]     trial;
    logic [DW:0]     diff;
    logic            ge;

    assign trial = {rem_reg, quo_reg[NW-1]};
    assign diff  = trial - {1'b0, dvs_reg};
    assign ge    = (trial >= {1'b0, dvs_reg});

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNTW'(NW);
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? diff[DW-1:0] : trial[DW-1:0];
            quo_next = {quo_reg[NW-2:0], ge};
            cnt_next = cnt_reg - CNTW'(1);
            if (cnt_reg == CNTW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            quo_reg  <= '0;
            rem_reg  <= '0;
            dvs_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
            quo_reg  <= quo_next;
            rem_reg  <= rem_next;
            dvs_reg  <= dvs_next;
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;
endmodule

FILE: rtl/com_isqrt.sv
// Digit-by-digit integer square root, two radicand bits per cycle.
// Depends on com_pkg for the radicand width.
module com_isqrt (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [com_pkg::SQ_W-1:0]   radicand,
    output logic                       done,
    output logic [com_pkg::VAL_W-1:0]  root
);
    import com_pkg::*;

    localparam int RW   = VAL_W + 3;
    localparam int CNTW = $clog2(VAL_W + 1);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNTW-1:0]  cnt_reg, cnt_next;
    logic [SQ_W-1:0]  val_reg, val_next;
    logic [RW-1:0]    rem_reg, rem_next;
    logic [VAL_W-1:0] root_reg, root_next;
    logic [RW-1:0]    shifted;
    logic [RW-1:0]    trial;
    logic             ge;

    assign shifted = {rem_reg[RW-3:0], val_reg[SQ_W-1:SQ_W-2]};
    assign trial   = {1'b0, root_reg, 2'b01};
    assign ge      = (shifted >= trial);

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        val_next  = val_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNTW'(VAL_W);
            val_next  = radicand;
            rem_next  = '0;
            root_next = '0;
        end
        else if (busy_reg)
        begin
            val_next  = {val_reg[SQ_W-3:0], 2'b00};
            rem_next  = ge ? (shifted - trial) : shifted;
            root_next = {root_reg[VAL_W-2:0], ge};
            cnt_next  = cnt_reg - CNTW'(1);
            if (cnt_reg == CNTW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            val_reg  <= '0;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
            val_reg  <= val_next;
            rem_reg  <= rem_next;
            root_reg <= root_next;
        end
    end

    assign done = done_reg;
    assign root = root_reg;
endmodule

FILE: rtl/com_mul.sv
// Shift-and-add multiplier taking one multiplier bit per cycle.
// Depends on com_pkg for the operand and product widths.
module com_mul (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [com_pkg::VAL_W-1:0] op_a,
    input  logic [com_pkg::VAL_W-1:0] op_b,
    output logic                      done,
    output logic [com_pkg::SQ_W-1:0]  product
);
    import com_pkg::*;

    localparam int CNTW = $clog2(VAL_W + 1);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNTW-1:0]  cnt_reg, cnt_next;
    logic [SQ_W-1:0]  a_reg, a_next;
    logic [VAL_W-1:0] b_reg, b_next;
    logic [SQ_W-1:0]  acc_reg, acc_next;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        acc_next  = acc_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNTW'(VAL_W);
            a_next    = SQ_W'(op_a);
            b_next    = op_b;
            acc_next  = '0;
        end
        else if (busy_reg)
        begin
            if (b_reg[0])
            begin
                acc_next = acc_reg + a_reg;
            end
            a_next   = {a_reg[SQ_W-2:0], 1'b0};
            b_next   = {1'b0, b_reg[VAL_W-1:1]};
            cnt_next = cnt_reg - CNTW'(1);
            if (cnt_reg == CNTW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            a_reg    <= '0;
            b_reg    <= '0;
            acc_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
            a_reg    <= a_next;
            b_reg    <= b_next;
            acc_reg  <= acc_next;
        end
    end

    assign done    = done_reg;
    assign product = acc_reg;
endmodule

FILE: rtl/chauvenet_outlier_mean_core.sv
// Outlier-rejected mean core: sample store, pass sequencer and result register.
// Depends on com_pkg, com_div, com_isqrt, com_mul and the assertion macro header.
//
// Samples arrive on the input channel (in_valid/in_ready), one transaction per
// sample, and are taken while the core is idle. A sample with
// last_sample set closes the set and starts the computation; no further samples
// are taken until the result has been placed in the output register.
// The result leaves on the output channel (out_valid/out_ready) as one
// transaction. For a set of two or more samples the core runs a summing pass
// over the store, a bit-serial variance pass whose multiplier dominates, up to
// three bit-serial divisions, a bit-serial root and a rejection pass.
// The rejection factor is written through the configuration channel
// (cfg_valid/cfg_ready, always ready); the user must write it only while the
// core is idle, which the core itself does not enforce.
// Reset empties the set and restores the factor to 1.54. A stalled receiver
// holds the result in the output register; a new set may be loaded meanwhile,
// and its computation waits only when its own result is ready to be placed.
`include "chauvenet_outlier_mean_core_defines.svh"
module chauvenet_outlier_mean_core #(
    parameter int MAX_SAMPLES = com_pkg::MAX_SAMPLES_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [com_pkg::SAMPLE_W-1:0]     sample_value,
    input  logic                             last_sample,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [com_pkg::VAL_W-1:0]        mean_value,
    output logic [com_pkg::VAL_W-1:0]        std_dev,
    output logic [com_pkg::COUNT_OUT_W-1:0]  kept_count,
    output logic [com_pkg::COUNT_OUT_W-1:0]  total_count,
    output logic                             degenerate,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [com_pkg::FACTOR_W-1:0]     cfg_data
);
    import com_pkg::*;

    localparam int AW    = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
    localparam int CW    = $clog2(MAX_SAMPLES + 1);
    localparam int SW    = SAMPLE_W + CW;
    localparam int NW    = SQ_W + CW;
    localparam int THR_W = FACTOR_W + VAL_W;

    typedef enum logic [4:0] {
        S_IDLE, S_SUM_RD, S_SUM_ACC, S_MEAN_GO, S_MEAN_WT,
        S_VAR_RD, S_VAR_GO, S_VAR_WT, S_VDIV_GO, S_VDIV_WT,
        S_SQRT_GO, S_SQRT_WT, S_THR_GO, S_THR_WT,
        S_REJ_RD, S_REJ_ACC, S_KDIV_GO, S_KDIV_WT, S_OUT
    } state_t;

    logic [SAMPLE_W-1:0] sample_store [MAX_SAMPLES];
    logic [SAMPLE_W-1:0] rdata_reg;

    state_t              state_reg, state_next;
    logic [CW-1:0]       loaded_reg, loaded_next;
    logic [CW-1:0]       n_reg, n_next;
    logic [CW-1:0]       idx_reg, idx_next;
    logic [SW-1:0]       sum_reg, sum_next;
    logic [VAL_W-1:0]    mean_reg, mean_next;
    logic [NW-1:0]       acc_reg, acc_next;
    logic [VAL_W-1:0]    std_reg, std_next;
    logic [THR_W-1:0]    thr_reg, thr_next;
    logic [SW-1:0]       ksum_reg, ksum_next;
    logic [CW-1:0]       kept_reg, kept_next;
    logic [VAL_W-1:0]    res_mean_reg, res_mean_next;
    logic                res_degen_reg, res_degen_next;
    logic [FACTOR_W-1:0] factor_reg, factor_next;
    logic                out_valid_reg, out_valid_next;
    logic [VAL_W-1:0]    out_mean_reg, out_mean_next;
    logic [VAL_W-1:0]    out_std_reg, out_std_next;
    logic [CW-1:0]       out_kept_reg, out_kept_next;
    logic [CW-1:0]       out_total_reg, out_total_next;
    logic                out_degen_reg, out_degen_next;

    logic                in_fire;
    logic                store_free;
    logic                last_idx;
    logic [VAL_W-1:0]    x_q;
    logic [VAL_W-1:0]    dev;
    logic                keep;

    logic                div_start, div_done;
    logic [NW-1:0]       div_dividend, div_quotient;
    logic [CW-1:0]       div_divisor;
    logic                mul_start, mul_done;
    logic [VAL_W-1:0]    mul_a, mul_b;
    logic [SQ_W-1:0]     mul_product;
    logic                sqrt_start, sqrt_done;
    logic [SQ_W-1:0]     sqrt_radicand;
    logic [VAL_W-1:0]    sqrt_root;

    assign in_ready   = (state_reg == S_IDLE);
    assign in_fire    = in_valid && in_ready;
    assign store_free = (loaded_reg < CW'(MAX_SAMPLES));
    assign last_idx   = (idx_reg == (n_reg - CW'(1)));
    assign x_q        = {rdata_reg, {FRAC_W{1'b0}}};
    assign dev        = (x_q >= mean_reg) ? (x_q - mean_reg) : (mean_reg - x_q);
    assign keep       = (THR_W'({dev, {FRAC_W{1'b0}}}) <= thr_reg);
    assign cfg_ready  = 1'b1;

    always_ff @(posedge clk)
    begin
        if (in_fire && store_free)
        begin
            sample_store[loaded_reg[AW-1:0]] <= sample_value;
        end
        rdata_reg <= sample_store[idx_reg[AW-1:0]];
    end

    always_comb
    begin
        div_start    = (state_reg == S_MEAN_GO) || (state_reg == S_VDIV_GO)
                       || (state_reg == S_KDIV_GO);
        div_dividend = NW'({sum_reg, {FRAC_W{1'b0}}});
        div_divisor  = n_reg;
        unique case (state_reg)
            S_VDIV_GO:
            begin
                div_dividend = acc_reg;
                div_divisor  = n_reg - CW'(1);
            end
            S_KDIV_GO:
            begin
                div_dividend = NW'({ksum_reg, {FRAC_W{1'b0}}});
                div_divisor  = kept_reg;
            end
            default:
            begin
                div_dividend = NW'({sum_reg, {FRAC_W{1'b0}}});
                div_divisor  = n_reg;
            end
        endcase
        mul_start     = (state_reg == S_VAR_GO) || (state_reg == S_THR_GO);
        mul_a         = (state_reg == S_THR_GO) ? std_reg : dev;
        mul_b         = (state_reg == S_THR_GO) ? VAL_W'(factor_reg) : dev;
        sqrt_start    = (state_reg == S_SQRT_GO);
        sqrt_radicand = (div_quotient[NW-1:SQ_W] != '0) ? {SQ_W{1'b1}}
                                                         : div_quotient[SQ_W-1:0];
    end

    com_div #(.NW(NW), .DW(CW)) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quotient)
    );

    com_mul u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .op_a    (mul_a),
        .op_b    (mul_b),
        .done    (mul_done),
        .product (mul_product)
    );

    com_isqrt u_isqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sqrt_start),
        .radicand (sqrt_radicand),
        .done     (sqrt_done),
        .root     (sqrt_root)
    );

    always_comb
    begin
        state_next     = state_reg;
        loaded_next    = loaded_reg;
        n_next         = n_reg;
        idx_next       = idx_reg;
        sum_next       = sum_reg;
        mean_next      = mean_reg;
        acc_next       = acc_reg;
        std_next       = std_reg;
        thr_next       = thr_reg;
        ksum_next      = ksum_reg;
        kept_next      = kept_reg;
        res_mean_next  = res_mean_reg;
        res_degen_next = res_degen_reg;
        factor_next    = factor_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_mean_next  = out_mean_reg;
        out_std_next   = out_std_reg;
        out_kept_next  = out_kept_reg;
        out_total_next = out_total_reg;
        out_degen_next = out_degen_reg;

        if (cfg_valid && cfg_ready)
        begin
            factor_next = cfg_data;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    if (store_free)
                    begin
                        loaded_next = loaded_reg + CW'(1);
                    end
                    if (last_sample)
                    begin
                        n_next     = store_free ? (loaded_reg + CW'(1)) : loaded_reg;
                        idx_next   = '0;
                        sum_next   = '0;
                        state_next = S_SUM_RD;
                    end
                end
            end
            S_SUM_RD:
            begin
                state_next = S_SUM_ACC;
            end
            S_SUM_ACC:
            begin
                sum_next = sum_reg + SW'(rdata_reg);
                idx_next = idx_reg + CW'(1);
                state_next = last_idx ? S_MEAN_GO : S_SUM_RD;
            end
            S_MEAN_GO:
            begin
                state_next = S_MEAN_WT;
            end
            S_MEAN_WT:
            begin
                if (div_done)
                begin
                    mean_next = div_quotient[VAL_W-1:0];
                    if (n_reg < CW'(2))
                    begin
                        res_mean_next  = div_quotient[VAL_W-1:0];
                        std_next       = '0;
                        kept_next      = n_reg;
                        res_degen_next = 1'b1;
                        state_next     = S_OUT;
                    end
                    else
                    begin
                        idx_next   = '0;
                        acc_next   = '0;
                        state_next = S_VAR_RD;
                    end
                end
            end
            S_VAR_RD:
            begin
                state_next = S_VAR_GO;
            end
            S_VAR_GO:
            begin
                state_next = S_VAR_WT;
            end
            S_VAR_WT:
            begin
                if (mul_done)
                begin
                    acc_next   = acc_reg + NW'(mul_product);
                    idx_next   = idx_reg + CW'(1);
                    state_next = last_idx ? S_VDIV_GO : S_VAR_RD;
                end
            end
            S_VDIV_GO:
            begin
                state_next = S_VDIV_WT;
            end
            S_VDIV_WT:
            begin
                if (div_done)
                begin
                    state_next = S_SQRT_GO;
                end
            end
            S_SQRT_GO:
            begin
                state_next = S_SQRT_WT;
            end
            S_SQRT_WT:
            begin
                if (sqrt_done)
                begin
                    std_next   = sqrt_root;
                    state_next = S_THR_GO;
                end
            end
            S_THR_GO:
            begin
                state_next = S_THR_WT;
            end
            S_THR_WT:
            begin
                if (mul_done)
                begin
                    thr_next   = mul_product[THR_W-1:0];
                    idx_next   = '0;
                    ksum_next  = '0;
                    kept_next  = '0;
                    state_next = S_REJ_RD;
                end
            end
            S_REJ_RD:
            begin
                state_next = S_REJ_ACC;
            end
            S_REJ_ACC:
            begin
                if (keep)
                begin
                    ksum_next = ksum_reg + SW'(rdata_reg);
                    kept_next = kept_reg + CW'(1);
                end
                idx_next   = idx_reg + CW'(1);
                state_next = last_idx ? S_KDIV_GO : S_REJ_RD;
            end
            S_KDIV_GO:
            begin
                if (kept_reg == '0)
                begin
                    res_mean_next  = '0;
                    res_degen_next = 1'b1;
                    state_next     = S_OUT;
                end
                else
                begin
                    state_next = S_KDIV_WT;
                end
            end
            S_KDIV_WT:
            begin
                if (div_done)
                begin
                    res_mean_next  = div_quotient[VAL_W-1:0];
                    res_degen_next = 1'b0;
                    state_next     = S_OUT;
                end
            end
            S_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    out_mean_next  = res_mean_reg;
                    out_std_next   = std_reg;
                    out_kept_next  = kept_reg;
                    out_total_next = n_reg;
                    out_degen_next = res_degen_reg;
                    loaded_next    = '0;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            loaded_reg    <= '0;
            n_reg         <= '0;
            idx_reg       <= '0;
            sum_reg       <= '0;
            mean_reg      <= '0;
            acc_reg       <= '0;
            std_reg       <= '0;
            thr_reg       <= '0;
            ksum_reg      <= '0;
            kept_reg      <= '0;
            res_mean_reg  <= '0;
            res_degen_reg <= 1'b0;
            factor_reg    <= FACTOR_RESET;
            out_valid_reg <= 1'b0;
            out_mean_reg  <= '0;
            out_std_reg   <= '0;
            out_kept_reg  <= '0;
            out_total_reg <= '0;
            out_degen_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            loaded_reg    <= loaded_next;
            n_reg         <= n_next;
            idx_reg       <= idx_next;
            sum_reg       <= sum_next;
            mean_reg      <= mean_next;
            acc_reg       <= acc_next;
            std_reg       <= std_next;
            thr_reg       <= thr_next;
            ksum_reg      <= ksum_next;
            kept_reg      <= kept_next;
            res_mean_reg  <= res_mean_next;
            res_degen_reg <= res_degen_next;
            factor_reg    <= factor_next;
            out_valid_reg <= out_valid_next;
            out_mean_reg  <= out_mean_next;
            out_std_reg   <= out_std_next;
            out_kept_reg  <= out_kept_next;
            out_total_reg <= out_total_next;
            out_degen_reg <= out_degen_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign mean_value  = out_mean_reg;
    assign std_dev     = out_std_reg;
    assign kept_count  = COUNT_OUT_W'(out_kept_reg);
    assign total_count = COUNT_OUT_W'(out_total_reg);
    assign degenerate  = out_degen_reg;

    `COM_ASSERT(a_loaded_bound, loaded_reg <= CW'(MAX_SAMPLES))
    `COM_ASSERT_IMPL(a_kept_bound, state_reg == S_OUT, kept_reg <= n_reg)
    `COM_ASSERT_IMPL(a_kept_flag, out_valid_reg && !out_degen_reg, out_kept_reg != '0)
    `COM_ASSERT_IMPL(a_set_cleared, $rose(out_valid_reg), loaded_reg == '0)
endmodule
